// ===== hw/rtl/voxel_face_culling_mesher_unit_assert.svh =====
// Assertion macros shared by the mesher RTL.
// Uses clk_i and rst_ni of the including module for the default form.
`ifndef VOXEL_FACE_CULLING_MESHER_UNIT_ASSERT_SVH
`define VOXEL_FACE_CULLING_MESHER_UNIT_ASSERT_SVH

// check prop on every rising edge of clk, off while rst_n is low
`define VFM_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mesher assertion failed");

// default clock and reset of the module
`define VFM_ASSERT(label, prop) `VFM_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

// ===== hw/rtl/vfm_pkg.sv =====
// Shared types and constants of the voxel face culling mesher.
// No dependencies.
package vfm_pkg;

  localparam int EDGE_DEF       = 16;
  localparam int ATLAS_ROWS_DEF = 19;
  localparam int TYPE_COUNT_DEF = 256;
  localparam int FIFO_DEPTH     = 4;

  localparam logic [14:0] COUNT_MAX = 15'h7FFF;

  localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_Z = 2'd2;

  typedef enum logic [1:0] {
    KIND_WRITE_CELL = 2'd0,
    KIND_SET_ROW    = 2'd1,
    KIND_MESH       = 2'd2,
    KIND_BEGIN      = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CENTER,
    ST_SCAN,
    ST_EMIT
  } st_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  x;
    logic [3:0]  y;
    logic [3:0]  z;
    logic [7:0]  block_type;
    logic [4:0]  row;
  } cmd_t;

  typedef struct packed {
    logic [16:0] base_vertex;
    logic [4:0]  row_bottom;
    logic [4:0]  row_top;
    logic [2:0]  face_index;
    logic [21:0] world_z;
    logic [21:0] world_y;
    logic [21:0] world_x;
  } face_rec_t;

endpackage

// ===== hw/rtl/voxel_face_culling_mesher_unit.sv =====
// Voxel chunk face culling mesher, top level: origin registers and wiring.
// Depends on vfm_pkg, vfm_front, vfm_cmd_fifo and vfm_back.
//
// Input items arrive on s_axis: tuser carries the kind (write cell, set texture
// row, mesh cell, begin mesh), tdata the cell coordinates, block type and row.
// Face records leave on m_axis, tlast marking the final face of a mesh request.
// Origins are written through cfg_we_i / cfg_index_i / cfg_wdata_i while idle.
// Items pass a four-entry command queue into the back part, so the front keeps
// accepting while the back works or waits on the receiver.
// Write, row and begin items are taken from the queue in the idle state of the
// back part. A mesh request pops the queue with the center read, then checks the
// six neighbors read from the cell store in the scan state, then loads each due
// face into the output register as that register frees up (an empty emit state
// when none is due); an air cell goes back to idle after the center state.
// A stalled receiver holds the output register; the back part then stops, the
// queue fills and s_axis_tready falls.
// Reset clears the queue, the face counter, the origins and the output valid;
// the cell store and row table are not cleared and must be written first.
module voxel_face_culling_mesher_unit #(
  parameter int EDGE       = vfm_pkg::EDGE_DEF,
  parameter int ATLAS_ROWS = vfm_pkg::ATLAS_ROWS_DEF,
  parameter int TYPE_COUNT = vfm_pkg::TYPE_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_x, cell_y, cell_z, block_type, row_value, zero pad
  input  logic [31:0] s_axis_tdata,
  // kind
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // world_x, world_y, world_z, face_index, row_top, row_bottom, base_vertex
  output logic [95:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [20:0] cfg_wdata_i
);

  logic [20:0] origin_x_q, origin_y_q, origin_z_q;

  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  vfm_pkg::cmd_t      cmd_in;
  vfm_pkg::cmd_t      cmd_out;
  vfm_pkg::face_rec_t rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= '0;
      origin_y_q <= '0;
      origin_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        vfm_pkg::CFG_ORIGIN_X: origin_x_q <= cfg_wdata_i;
        vfm_pkg::CFG_ORIGIN_Y: origin_y_q <= cfg_wdata_i;
        vfm_pkg::CFG_ORIGIN_Z: origin_z_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  vfm_front #(
    .EDGE       (EDGE),
    .ATLAS_ROWS (ATLAS_ROWS),
    .TYPE_COUNT (TYPE_COUNT)
  ) u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_kind_i  (s_axis_tuser),
    .in_x_i     (s_axis_tdata[3:0]),
    .in_y_i     (s_axis_tdata[7:4]),
    .in_z_i     (s_axis_tdata[11:8]),
    .in_type_i  (s_axis_tdata[19:12]),
    .in_row_i   (s_axis_tdata[24:20]),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (cmd_in)
  );

  vfm_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (cmd_out),
    .empty_o (q_empty)
  );

  vfm_back #(
    .EDGE       (EDGE),
    .TYPE_COUNT (TYPE_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_cmd_i     (cmd_out),
    .q_pop_o     (q_pop),
    .origin_x_i  (origin_x_q),
    .origin_y_i  (origin_y_q),
    .origin_z_i  (origin_z_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_rec_o   (rec),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = rec;

endmodule

// ===== hw/rtl/vfm_front.sv =====
// Front part: accepts input items, drops those without effect, builds commands.
// Depends on vfm_pkg.
module vfm_front #(
  parameter int EDGE       = vfm_pkg::EDGE_DEF,
  parameter int ATLAS_ROWS = vfm_pkg::ATLAS_ROWS_DEF,
  parameter int TYPE_COUNT = vfm_pkg::TYPE_COUNT_DEF
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_kind_i,
  input  logic [3:0]         in_x_i,
  input  logic [3:0]         in_y_i,
  input  logic [3:0]         in_z_i,
  input  logic [7:0]         in_type_i,
  input  logic [4:0]         in_row_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output vfm_pkg::cmd_t      q_cmd_o
);

  localparam int RowLim = (ATLAS_ROWS - 1 > 30) ? 30 : ATLAS_ROWS - 1;

  logic in_bounds;
  logic keep;
  logic [4:0] row_sat;

  assign in_bounds = (int'(in_x_i) < EDGE) && (int'(in_y_i) < EDGE) && (int'(in_z_i) < EDGE);
  assign row_sat   = (int'(in_row_i) > RowLim) ? 5'(RowLim) : in_row_i;

  always_comb begin
    case (vfm_pkg::kind_e'(in_kind_i))
      vfm_pkg::KIND_WRITE_CELL: keep = in_bounds;
      vfm_pkg::KIND_SET_ROW:    keep = ({1'b0, in_type_i} < 9'(TYPE_COUNT));
      vfm_pkg::KIND_MESH:       keep = in_bounds;
      vfm_pkg::KIND_BEGIN:      keep = 1'b1;
      default:                  keep = 1'b0;
    endcase
  end

  assign in_ready_o         = !q_full_i;
  assign q_push_o           = in_valid_i && !q_full_i && keep;
  assign q_cmd_o.kind       = vfm_pkg::kind_e'(in_kind_i);
  assign q_cmd_o.x          = in_x_i;
  assign q_cmd_o.y          = in_y_i;
  assign q_cmd_o.z          = in_z_i;
  assign q_cmd_o.block_type = in_type_i;
  assign q_cmd_o.row        = row_sat;

endmodule

// ===== hw/rtl/vfm_cmd_fifo.sv =====
// Short command queue between front and back parts.
// Depends on vfm_pkg.
module vfm_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vfm_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output vfm_pkg::cmd_t cmd_o,
  output logic          empty_o
);

  localparam int Depth = vfm_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(Depth);

  vfm_pkg::cmd_t mem_q [Depth];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ===== hw/rtl/vfm_back.sv =====
// Back part: cell store, row table, neighbor scan and face emission.
// Depends on vfm_pkg and voxel_face_culling_mesher_unit_assert.svh.
`include "voxel_face_culling_mesher_unit_assert.svh"
module vfm_back #(
  parameter int EDGE       = vfm_pkg::EDGE_DEF,
  parameter int TYPE_COUNT = vfm_pkg::TYPE_COUNT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  vfm_pkg::cmd_t      q_cmd_i,
  output logic               q_pop_o,
  input  logic [20:0]        origin_x_i,
  input  logic [20:0]        origin_y_i,
  input  logic [20:0]        origin_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vfm_pkg::face_rec_t out_rec_o,
  output logic               out_last_o
);

  localparam int Cells = EDGE * EDGE * EDGE;
  localparam int AW    = $clog2(Cells);
  localparam int TW    = $clog2(TYPE_COUNT);

  function automatic logic [AW-1:0] cell_index(input logic [4:0] cx, input logic [4:0] cy,
                                               input logic [4:0] cz);
    cell_index = AW'((int'(cx) * EDGE + int'(cy)) * EDGE + int'(cz));
  endfunction

  logic [7:0] cell_mem [Cells];
  logic [4:0] row_mem  [TYPE_COUNT];

  vfm_pkg::st_e state_q, state_d;
  logic [3:0]  x_q, y_q, z_q;
  logic [2:0]  chk_q, chk_d;
  logic [5:0]  mask_q, mask_d;
  logic [14:0] cnt_q, cnt_d;
  logic [7:0]  cell_rd_q;
  logic [4:0]  row_rd_q;
  logic        type_ok_q;
  logic        nbr_out_q;
  logic        out_valid_q;
  logic        out_last_q;
  vfm_pkg::face_rec_t out_rec_q;

  logic          pop;
  logic          load;
  logic [2:0]    fi;
  logic [4:0]    nx, ny, nz;
  logic          nbr_in;
  logic [AW-1:0] head_addr, nbr_addr, rd_addr;
  logic [2:0]    pick;
  logic [5:0]    rem;
  logic [4:0]    row;

  // neighbor of the latched cell for the face being fetched
  assign fi = (state_q == vfm_pkg::ST_CENTER) ? 3'd0 : chk_q + 3'd1;

  always_comb begin
    nx     = {1'b0, x_q};
    ny     = {1'b0, y_q};
    nz     = {1'b0, z_q};
    nbr_in = 1'b1;
    case (vfm_pkg::face_e'(fi))
      vfm_pkg::FACE_POS_X: nx = {1'b0, x_q} + 5'd1;
      vfm_pkg::FACE_NEG_X: begin
        nx     = {1'b0, x_q} - 5'd1;
        nbr_in = (x_q != 4'd0);
      end
      vfm_pkg::FACE_POS_Y: ny = {1'b0, y_q} + 5'd1;
      vfm_pkg::FACE_NEG_Y: begin
        ny     = {1'b0, y_q} - 5'd1;
        nbr_in = (y_q != 4'd0);
      end
      vfm_pkg::FACE_POS_Z: nz = {1'b0, z_q} + 5'd1;
      vfm_pkg::FACE_NEG_Z: begin
        nz     = {1'b0, z_q} - 5'd1;
        nbr_in = (z_q != 4'd0);
      end
      default: nbr_in = 1'b0;
    endcase
    nbr_in = nbr_in && (int'(nx) < EDGE) && (int'(ny) < EDGE) && (int'(nz) < EDGE);
  end

  assign head_addr = cell_index({1'b0, q_cmd_i.x}, {1'b0, q_cmd_i.y}, {1'b0, q_cmd_i.z});
  assign nbr_addr  = cell_index(nx, ny, nz);
  assign rd_addr   = (state_q == vfm_pkg::ST_IDLE) ? head_addr : nbr_addr;

  always_comb begin
    pick = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (mask_q[i]) begin
        pick = 3'(i);
      end
    end
  end

  assign rem = mask_q & (mask_q - 6'd1);
  assign row = type_ok_q ? row_rd_q : 5'd0;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      vfm_pkg::ST_IDLE: begin
        if (!q_empty_i && q_cmd_i.kind == vfm_pkg::KIND_MESH) begin
          state_d = vfm_pkg::ST_CENTER;
        end
      end
      vfm_pkg::ST_CENTER: begin
        state_d = (cell_rd_q == 8'd0) ? vfm_pkg::ST_IDLE : vfm_pkg::ST_SCAN;
      end
      vfm_pkg::ST_SCAN: begin
        if (chk_q == 3'd5) begin
          state_d = vfm_pkg::ST_EMIT;
        end
      end
      vfm_pkg::ST_EMIT: begin
        if (mask_q == 6'd0 || (load && rem == 6'd0)) begin
          state_d = vfm_pkg::ST_IDLE;
        end
      end
      default: state_d = vfm_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    pop    = (state_q == vfm_pkg::ST_IDLE) && !q_empty_i;
    load   = (state_q == vfm_pkg::ST_EMIT) && (mask_q != 6'd0)
             && (!out_valid_q || out_ready_i);
    chk_d  = chk_q;
    mask_d = mask_q;
    cnt_d  = cnt_q;
    case (state_q)
      vfm_pkg::ST_IDLE: begin
        if (pop && q_cmd_i.kind == vfm_pkg::KIND_BEGIN) begin
          cnt_d = '0;
        end
      end
      vfm_pkg::ST_CENTER: begin
        chk_d  = 3'd0;
        mask_d = 6'd0;
      end
      vfm_pkg::ST_SCAN: begin
        chk_d         = chk_q + 3'd1;
        mask_d[chk_q] = nbr_out_q || (cell_rd_q == 8'd0);
      end
      vfm_pkg::ST_EMIT: begin
        if (load) begin
          mask_d = rem;
          if (cnt_q != vfm_pkg::COUNT_MAX) begin
            cnt_d = cnt_q + 15'd1;
          end
        end
      end
      default: chk_d = 3'd0;
    endcase
  end

  assign q_pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vfm_pkg::ST_IDLE;
      chk_q       <= '0;
      mask_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      chk_q   <= chk_d;
      mask_q  <= mask_d;
      cnt_q   <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_cmd_i.kind == vfm_pkg::KIND_MESH) begin
      x_q <= q_cmd_i.x;
      y_q <= q_cmd_i.y;
      z_q <= q_cmd_i.z;
    end
    if (load) begin
      out_rec_q.world_x     <= {origin_x_i[20], origin_x_i} + {18'd0, x_q};
      out_rec_q.world_y     <= {origin_y_i[20], origin_y_i} + {18'd0, y_q};
      out_rec_q.world_z     <= {origin_z_i[20], origin_z_i} + {18'd0, z_q};
      out_rec_q.face_index  <= pick;
      out_rec_q.row_top     <= row;
      out_rec_q.row_bottom  <= row + 5'd1;
      out_rec_q.base_vertex <= {cnt_q, 2'b00};
      out_last_q            <= (rem == 6'd0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_cmd_i.kind == vfm_pkg::KIND_WRITE_CELL) begin
      cell_mem[head_addr] <= q_cmd_i.block_type;
    end
    cell_rd_q <= cell_mem[rd_addr];
    nbr_out_q <= !nbr_in;
  end

  always_ff @(posedge clk_i) begin
    if (pop && q_cmd_i.kind == vfm_pkg::KIND_SET_ROW) begin
      row_mem[q_cmd_i.block_type[TW-1:0]] <= q_cmd_i.row;
    end
    if (state_q == vfm_pkg::ST_CENTER) begin
      row_rd_q  <= row_mem[cell_rd_q[TW-1:0]];
      type_ok_q <= ({1'b0, cell_rd_q} < 9'(TYPE_COUNT));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;
  assign out_last_o  = out_last_q;

  `VFM_ASSERT(a_out_from_emit, $rose(out_valid_q) |-> $past(state_q == vfm_pkg::ST_EMIT))
  `VFM_ASSERT(a_scan_bound, state_q == vfm_pkg::ST_SCAN |-> chk_q <= 3'd5)
  `VFM_ASSERT(a_last_ends, load && rem == 6'd0 |=> state_q == vfm_pkg::ST_IDLE)
  `VFM_ASSERT(a_cnt_moves,
    !$stable(cnt_q) |-> $past(load || (pop && q_cmd_i.kind == vfm_pkg::KIND_BEGIN)))

endmodule
